[rtl/core/spq_pkg.sv]
package spq_pkg;

  localparam int KEY_W            = 32;
  localparam int HANDLE_W         = 16;
  localparam int DEFAULT_CAPACITY = 64;

  // operation codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_POP    = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                       ins;
    logic                       pop;
    logic signed [KEY_W-1:0]    key;
    logic        [HANDLE_W-1:0] handle;
  } cell_cmd_t;

endpackage

[rtl/core/spq_cell.sv]
module spq_cell
  import spq_pkg::*;
#(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic                       clk,
  input  cell_cmd_t                  cmd,
  input  logic                       valid_i,
  input  logic                       prev_take_i,
  input  logic signed [KEY_W-1:0]    left_key_i,
  input  logic        [HANDLE_W-1:0] left_handle_i,
  input  logic signed [KEY_W-1:0]    right_key_i,
  input  logic        [HANDLE_W-1:0] right_handle_i,
  output logic                       take_o,
  output logic signed [KEY_W-1:0]    key_o,
  output logic        [HANDLE_W-1:0] handle_o
);

  logic signed [KEY_W-1:0]    key_r;
  logic signed [KEY_W-1:0]    key_nxt;
  logic        [HANDLE_W-1:0] handle_r;
  logic        [HANDLE_W-1:0] handle_nxt;
  logic                       wins;

  // the head needs a strictly larger key, later cells accept an equal one
  assign wins   = IS_HEAD ? (cmd.key > key_r) : (cmd.key >= key_r);
  assign take_o = !valid_i || wins;

  // pick the next word: shift from the left, load the new word, shift from the right or hold
  always_comb begin
    key_nxt    = key_r;
    handle_nxt = handle_r;
    if (cmd.ins) begin
      if (prev_take_i) begin
        key_nxt    = left_key_i;
        handle_nxt = left_handle_i;
      end else if (take_o) begin
        key_nxt    = cmd.key;
        handle_nxt = cmd.handle;
      end
    end else if (cmd.pop) begin
      key_nxt    = right_key_i;
      handle_nxt = right_handle_i;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    handle_r <= handle_nxt;
  end

  assign key_o    = key_r;
  assign handle_o = handle_r;

endmodule

[rtl/core/sorted_priority_queue_top.sv]
// Sorted max-priority queue built as a row of CAPACITY cells, head in cell 0.
// Input channel (in_valid/in_ready) carries one operation word: mode selects
// insert (key, handle), pop of the head, or clear. Result channel
// (out_valid/out_ready) returns one word per operation: status, the popped
// key and handle (0 when nothing is popped), the count held afterwards and
// the head key afterwards (0 when empty).
// Every cell compares the broadcast key with its own in the same cycle and
// shifts with its neighbour, so the result is valid the cycle after the
// operation is accepted.
// One operation is taken per cycle while results are drained; a new
// operation is accepted in the cycle its predecessor's result is taken, as
// the result register is the only buffer between the two sides.
// If the receiver stalls, out_valid holds with the result unchanged and
// in_ready stays low until the result is taken.
// Reset empties the queue at once (count to zero); cell contents are not
// cleared and are never read until written.
// An insert into a full queue is dropped with status full; a pop on an
// empty queue returns status empty.
module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_mode,
  input  logic signed [KEY_W-1:0]    in_key,
  input  logic        [HANDLE_W-1:0] in_handle,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic signed [KEY_W-1:0]    out_popped_key,
  output logic        [HANDLE_W-1:0] out_popped_handle,
  output logic [CW-1:0]              out_entry_count,
  output logic signed [KEY_W-1:0]    out_top_key
);

  logic                       acc;
  logic                       full;
  logic                       empty;
  cell_cmd_t                  cmd;
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              count_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  status_t                    status_r;
  status_t                    status_nxt;
  logic signed [KEY_W-1:0]    pkey_r;
  logic signed [KEY_W-1:0]    pkey_nxt;
  logic        [HANDLE_W-1:0] phandle_r;
  logic        [HANDLE_W-1:0] phandle_nxt;

  logic signed [KEY_W-1:0]    cell_key   [CAPACITY];
  logic        [HANDLE_W-1:0] cell_handle[CAPACITY];
  logic                       cell_take  [CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);

  // decode the operation word into cell command, new count and result
  always_comb begin
    cmd.ins     = 1'b0;
    cmd.pop     = 1'b0;
    cmd.key     = in_key;
    cmd.handle  = in_handle;
    count_nxt   = count_r;
    status_nxt  = status_r;
    pkey_nxt    = pkey_r;
    phandle_nxt = phandle_r;
    if (acc) begin
      status_nxt  = STATUS_DONE;
      pkey_nxt    = '0;
      phandle_nxt = '0;
      unique case (mode_t'(in_mode))
        MODE_INSERT: begin
          if (full) begin
            status_nxt = STATUS_FULL;
          end else begin
            cmd.ins   = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        MODE_POP: begin
          if (empty) begin
            status_nxt = STATUS_EMPTY;
          end else begin
            cmd.pop     = 1'b1;
            count_nxt   = count_r - CW'(1);
            pkey_nxt    = cell_key[0];
            phandle_nxt = cell_handle[0];
          end
        end
        MODE_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  // hold the result until the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    pkey_r    <= pkey_nxt;
    phandle_r <= phandle_nxt;
  end

  // row of cells, each linked to its left and right neighbour
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                       cvalid;
    logic                       prev_take;
    logic signed [KEY_W-1:0]    lkey;
    logic        [HANDLE_W-1:0] lhandle;
    logic signed [KEY_W-1:0]    rkey;
    logic        [HANDLE_W-1:0] rhandle;

    assign cvalid = (count_r > CW'(i));

    if (i == 0) begin : g_first
      assign prev_take = 1'b0;
      assign lkey      = '0;
      assign lhandle   = '0;
    end else begin : g_mid
      assign prev_take = cell_take[i-1];
      assign lkey      = cell_key[i-1];
      assign lhandle   = cell_handle[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rkey    = '0;
      assign rhandle = '0;
    end else begin : g_inner
      assign rkey    = cell_key[i+1];
      assign rhandle = cell_handle[i+1];
    end

    spq_cell #(
      .IS_HEAD (i == 0)
    ) u_cell (
      .clk            (clk),
      .cmd            (cmd),
      .valid_i        (cvalid),
      .prev_take_i    (prev_take),
      .left_key_i     (lkey),
      .left_handle_i  (lhandle),
      .right_key_i    (rkey),
      .right_handle_i (rhandle),
      .take_o         (cell_take[i]),
      .key_o          (cell_key[i]),
      .handle_o       (cell_handle[i])
    );
  end

  // count and head move only when a word is accepted, so read them live
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_popped_key    = pkey_r;
  assign out_popped_handle = phandle_r;
  assign out_entry_count   = count_r;
  assign out_top_key       = empty ? '0 : cell_key[0];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_mode == MODE_INSERT) && full |=> $stable(count_r))
    else $error("dropped insert changed the count");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_mode == MODE_POP) && !empty |=> count_r == $past(count_r) - CW'(1))
    else $error("pop did not remove one entry");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_FULL) |-> out_entry_count == CW'(CAPACITY))
    else $error("full status with room left");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int CAP         = DEFAULT_CAPACITY;
  localparam int CNT_W       = $clog2(CAP + 1);
  localparam int RANDOM_WORDS = 1200;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 5;
  // the mode field can carry a fourth code that the block treats as a no-op
  localparam logic [1:0] MODE_NOP = 2'd3;

  typedef struct {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] popped_key;
    logic [HANDLE_W-1:0]     popped_handle;
    logic [CNT_W-1:0]        entry_count;
    logic signed [KEY_W-1:0] top_key;
  } result_t;

  typedef struct {
    logic [1:0]              mode;
    logic signed [KEY_W-1:0] key;
    logic [HANDLE_W-1:0]     handle;
    int                      reps;
    bit                      typed;
    result_t                 want;
  } row_t;

  logic                       clk;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic [1:0]                 in_mode   = MODE_INSERT;
  logic signed [KEY_W-1:0]    in_key    = '0;
  logic        [HANDLE_W-1:0] in_handle = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [1:0]                 out_status;
  logic signed [KEY_W-1:0]    out_popped_key;
  logic        [HANDLE_W-1:0] out_popped_handle;
  logic [CNT_W-1:0]           out_entry_count;
  logic signed [KEY_W-1:0]    out_top_key;

  // expectation typed into the table, carried alongside the word on the wire
  bit      word_typed = 1'b0;
  result_t word_want;

  // shadow copy of the sorted store
  logic signed [KEY_W-1:0] shadow_key [CAP];
  logic [HANDLE_W-1:0]     shadow_handle [CAP];
  int                      shadow_count = 0;

  result_t pending_results [$];
  int      mismatches  = 0;
  int      idle_cycles = 0;
  bit      quiet       = 1'b0;
  row_t    dir_rows [$];

  sorted_priority_queue_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_key            (in_key),
    .in_handle         (in_handle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_popped_key    (out_popped_key),
    .out_popped_handle (out_popped_handle),
    .out_entry_count   (out_entry_count),
    .out_top_key       (out_top_key)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t res(input logic [1:0] st, input logic signed [KEY_W-1:0] pk,
                                  input logic [HANDLE_W-1:0] ph, input int cnt,
                                  input logic signed [KEY_W-1:0] top);
    result_t r;
    r.status        = st;
    r.popped_key    = pk;
    r.popped_handle = ph;
    r.entry_count   = CNT_W'(cnt);
    r.top_key       = top;
    return r;
  endfunction

  function automatic row_t mk_row(input logic [1:0] m, input logic signed [KEY_W-1:0] k,
                                  input logic [HANDLE_W-1:0] h, input int reps,
                                  input bit typed, input result_t want);
    row_t r;
    r.mode   = m;
    r.key    = k;
    r.handle = h;
    r.reps   = reps;
    r.typed  = typed;
    r.want   = want;
    return r;
  endfunction

  // Apply one operation to the shadow store and work out its result word
  task automatic queue_apply(input logic [1:0] m, input logic signed [KEY_W-1:0] k,
                             input logic [HANDLE_W-1:0] h, output result_t r);
    int  pos;
    bit  found;
    r = res(STATUS_DONE, '0, '0, 0, '0);
    case (m)
      MODE_INSERT: begin
        if (shadow_count >= CAP) begin
          r.status = STATUS_FULL;
        end else begin
          // head only on a strictly larger key, else before the first
          // later entry that is not larger, else at the tail
          if (shadow_count == 0 || k > shadow_key[0]) begin
            pos = 0;
          end else begin
            pos   = shadow_count;
            found = 1'b0;
            for (int i = 1; i < shadow_count; i++) begin
              if (!found && k >= shadow_key[i]) begin
                pos   = i;
                found = 1'b1;
              end
            end
          end
          for (int i = shadow_count; i > pos; i--) begin
            shadow_key[i]    = shadow_key[i-1];
            shadow_handle[i] = shadow_handle[i-1];
          end
          shadow_key[pos]    = k;
          shadow_handle[pos] = h;
          shadow_count++;
        end
      end
      MODE_POP: begin
        if (shadow_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.popped_key    = shadow_key[0];
          r.popped_handle = shadow_handle[0];
          for (int i = 1; i < shadow_count; i++) begin
            shadow_key[i-1]    = shadow_key[i];
            shadow_handle[i-1] = shadow_handle[i];
          end
          shadow_count--;
        end
      end
      MODE_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    r.entry_count = CNT_W'(shadow_count);
    r.top_key     = (shadow_count != 0) ? shadow_key[0] : '0;
  endtask

  // Check result words against the oldest expectation; predict accepted words
  always @(posedge clk) begin : track
    result_t want;
    result_t got;
    bit      moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          $error("result word with no expectation waiting");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_popped_key !== want.popped_key) begin
            $error("popped_key: expected %0d, got %0d", want.popped_key, out_popped_key);
            mismatches++;
          end
          if (out_popped_handle !== want.popped_handle) begin
            $error("popped_handle: expected %0d, got %0d",
                   want.popped_handle, out_popped_handle);
            mismatches++;
          end
          if (out_entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, out_entry_count);
            mismatches++;
          end
          if (out_top_key !== want.top_key) begin
            $error("top_key: expected %0d, got %0d", want.top_key, out_top_key);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        queue_apply(in_mode, in_key, in_handle, got);
        pending_results.push_back(word_typed ? word_want : got);
      end
    end
    idle_cycles <= moved ? 0 : idle_cycles + 1;
  end

  // Stall the result side at random, except in the quiet stretch
  always @(posedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 14);
  end

  // Hold one word on the input until taken, then idle at random outside the quiet stretch
  task automatic send_word(input logic [1:0] m, input logic signed [KEY_W-1:0] k,
                           input logic [HANDLE_W-1:0] h, input bit typed,
                           input result_t want);
    in_valid   <= 1'b1;
    in_mode    <= m;
    in_key     <= k;
    in_handle  <= h;
    word_typed <= typed;
    word_want  <= want;
    do @(posedge clk); while (!in_ready);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 14) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // Drop valid and hold off until every expected word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic signed [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 9))
      7:       return 32'sh7fffffff;
      8:       return 32'sh80000000;
      4, 5, 6: return KEY_W'(int'($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : drive
    result_t    none;
    logic [1:0] m;
    int         words;
    int         len;
    int         kind;
    none = res(STATUS_DONE, '0, '0, 0, '0);

    // empty-store corner cases, extremes, ties with the head and a full store
    dir_rows.push_back(mk_row(MODE_POP, 32'sh12345678, 16'h5a5a, 1, 1,
                              res(STATUS_EMPTY, '0, '0, 0, '0)));
    dir_rows.push_back(mk_row(MODE_CLEAR, '0, '0, 1, 1, res(STATUS_DONE, '0, '0, 0, '0)));
    dir_rows.push_back(mk_row(MODE_NOP, -1, 16'hffff, 1, 1, res(STATUS_DONE, '0, '0, 0, '0)));
    dir_rows.push_back(mk_row(MODE_INSERT, 32'sh7fffffff, 16'hffff, 1, 1,
                              res(STATUS_DONE, '0, '0, 1, 32'sh7fffffff)));
    dir_rows.push_back(mk_row(MODE_INSERT, 32'sh80000000, 16'h0000, 1, 1,
                              res(STATUS_DONE, '0, '0, 2, 32'sh7fffffff)));
    dir_rows.push_back(mk_row(MODE_INSERT, 32'sh7fffffff, 16'h0001, 1, 1,
                              res(STATUS_DONE, '0, '0, 3, 32'sh7fffffff)));
    dir_rows.push_back(mk_row(MODE_POP, '0, '0, 1, 1,
                              res(STATUS_DONE, 32'sh7fffffff, 16'hffff, 2, 32'sh7fffffff)));
    dir_rows.push_back(mk_row(MODE_POP, '0, '0, 1, 1,
                              res(STATUS_DONE, 32'sh7fffffff, 16'h0001, 1, 32'sh80000000)));
    dir_rows.push_back(mk_row(MODE_POP, '0, '0, 1, 1,
                              res(STATUS_DONE, 32'sh80000000, 16'h0000, 0, '0)));
    dir_rows.push_back(mk_row(MODE_INSERT, 0, 16'h1234, 1, 0, none));
    dir_rows.push_back(mk_row(MODE_INSERT, -1, 16'h5555, 1, 0, none));
    dir_rows.push_back(mk_row(MODE_INSERT, 5, 16'haaaa, 1, 0, none));
    dir_rows.push_back(mk_row(MODE_INSERT, 5, 16'h0f0f, 1, 0, none));
    dir_rows.push_back(mk_row(MODE_INSERT, 0, 16'h00ff, 1, 0, none));
    dir_rows.push_back(mk_row(MODE_NOP, 32'sh55aa55aa, 16'h0ff0, 1, 0, none));
    dir_rows.push_back(mk_row(MODE_POP, '0, '0, 1, 0, none));
    dir_rows.push_back(mk_row(MODE_CLEAR, '0, '0, 1, 1, res(STATUS_DONE, '0, '0, 0, '0)));
    dir_rows.push_back(mk_row(MODE_INSERT, 100, 16'h0000, CAP, 0, none));
    dir_rows.push_back(mk_row(MODE_INSERT, 32'sh7fffffff, 16'hffff, 1, 1,
                              res(STATUS_FULL, '0, '0, CAP, 100)));
    dir_rows.push_back(mk_row(MODE_NOP, '0, '0, 1, 0, none));
    dir_rows.push_back(mk_row(MODE_POP, '0, '0, 1, 0, none));
    dir_rows.push_back(mk_row(MODE_INSERT, -5, 16'hbeef, 1, 0, none));
    dir_rows.push_back(mk_row(MODE_POP, '0, '0, 1, 0, none));
    dir_rows.push_back(mk_row(MODE_CLEAR, '0, '0, 1, 1, res(STATUS_DONE, '0, '0, 0, '0)));

    // hold reset
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    foreach (dir_rows[r]) begin
      for (int j = 0; j < dir_rows[r].reps; j++) begin
        send_word(dir_rows[r].mode, dir_rows[r].key, HANDLE_W'(dir_rows[r].handle + j),
                  dir_rows[r].typed, dir_rows[r].want);
      end
    end
    drain_results();

    // random bursts: fills past full, drains past empty, mixed traffic, clears
    words = 0;
    while (words < RANDOM_WORDS) begin
      quiet = (words >= 500 && words < 800);
      if (!quiet && $urandom_range(0, 9) == 0) drain_results();
      kind = $urandom_range(0, 9);
      len  = (kind == 9) ? 1 : (kind >= 7) ? $urandom_range(1, 40) : $urandom_range(1, 70);
      for (int j = 0; j < len; j++) begin
        if (kind <= 3) begin
          m = MODE_INSERT;
        end else if (kind <= 6) begin
          m = MODE_POP;
        end else if (kind == 9) begin
          m = MODE_CLEAR;
        end else begin
          case ($urandom_range(0, 99)) inside
            [0:47]:  m = MODE_INSERT;
            [48:87]: m = MODE_POP;
            [88:93]: m = MODE_CLEAR;
            default: m = MODE_NOP;
          endcase
        end
        send_word(m, rand_key(), HANDLE_W'($urandom_range(0, 65535)), 1'b0, none);
        words++;
      end
    end
    quiet = 1'b0;

    // let the last words come back, then allow for the pipeline to settle
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_top.sv
tb/testbench.sv
